### sv/tics_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tics_pkg
// Shared types and constants for the timed intake color sorter.
// ----------------------------------------------------------------------------
package tics_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SORT_ENABLE   = 3'd0;
    localparam logic [2:0] REG_TEAM_IS_BLUE  = 3'd1;
    localparam logic [2:0] REG_EJECT_MS      = 3'd2;
    localparam logic [2:0] REG_TRAVEL_MS     = 3'd3;
    localparam logic [2:0] REG_COOLDOWN_MS   = 3'd4;
    localparam logic [2:0] REG_DEFAULT_SPEED = 3'd5;

    // Register reset values
    localparam logic [15:0]        EJECT_MS_RST      = 16'd500;
    localparam logic [15:0]        TRAVEL_MS_RST     = 16'd200;
    localparam logic [15:0]        COOLDOWN_MS_RST   = 16'd1000;
    localparam logic signed [10:0] DEFAULT_SPEED_RST = 11'sd600;

    // Hue bands in degrees
    localparam logic [8:0] RED_HUE_MAX  = 9'd25;
    localparam logic [8:0] BLUE_HUE_MIN = 9'd100;
    localparam logic [8:0] BLUE_HUE_MAX = 9'd220;

    // Speed limits: the most negative code negates to the positive limit
    localparam logic signed [10:0] SPEED_POS_MAX  = 11'sd1023;
    localparam logic [10:0]        SPEED_NEG_FULL = 11'h400;

    typedef struct packed {
        logic [1:0]        mode;
        logic [31:0]       now_ms;
        logic [8:0]        hue;
        logic [15:0]       run_time;
        logic signed [10:0] run_speed;
    } t_item;

endpackage

### sv/timed_intake_color_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_intake_color_sorter_top
// Conveyor motor command for a timed run with optional wrong-color ejection.
// ----------------------------------------------------------------------------
// Every item produces exactly one result. An item is registered on entry and
// its result is registered when the item leaves the input register, which
// happens only while the result register is empty or being read. One item
// is taken per cycle as long as the result side keeps up. The rate is set by
// the run state update, which reads and writes the state registers once per
// item. While a result waits on a stalled output, the input register takes
// one more transaction and then holds tready low. Configuration registers are
// written through the APB port (pready always high) and must only change while
// no item is in flight.
module timed_intake_color_sorter_top
    import tics_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [40:32] hue, [56:41] run_time, [67:57] run_speed, [71:68] zero
    input  logic [71:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] motor_velocity, [11] running, [12] ejecting, [13] ring_pending,
    // [15:14] zero
    output logic [15:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic               r_sort_enable;
    logic               r_team_is_blue;
    logic [15:0]        r_eject_ms;
    logic [15:0]        r_travel_ms;
    logic [15:0]        r_cooldown_ms;
    logic signed [10:0] r_default_speed;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_enable   <= 1'b0;
            r_team_is_blue  <= 1'b1;
            r_eject_ms      <= EJECT_MS_RST;
            r_travel_ms     <= TRAVEL_MS_RST;
            r_cooldown_ms   <= COOLDOWN_MS_RST;
            r_default_speed <= DEFAULT_SPEED_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SORT_ENABLE:   r_sort_enable   <= pwdata[0];
                REG_TEAM_IS_BLUE:  r_team_is_blue  <= pwdata[0];
                REG_EJECT_MS:      r_eject_ms      <= pwdata[15:0];
                REG_TRAVEL_MS:     r_travel_ms     <= pwdata[15:0];
                REG_COOLDOWN_MS:   r_cooldown_ms   <= pwdata[15:0];
                REG_DEFAULT_SPEED: r_default_speed <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SORT_ENABLE:   prdata = {31'd0, r_sort_enable};
            REG_TEAM_IS_BLUE:  prdata = {31'd0, r_team_is_blue};
            REG_EJECT_MS:      prdata = {16'd0, r_eject_ms};
            REG_TRAVEL_MS:     prdata = {16'd0, r_travel_ms};
            REG_COOLDOWN_MS:   prdata = {16'd0, r_cooldown_ms};
            REG_DEFAULT_SPEED: prdata = {{21{r_default_speed[10]}}, r_default_speed};
            default:           prdata = 32'd0;
        endcase
    end

    // Input register and result register handshake
    logic  r_in_valid;
    t_item r_in;
    logic  r_out_valid;
    logic  advance;
    logic  fire;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign fire          = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.mode      <= s_axis_tuser;
            r_in.now_ms    <= s_axis_tdata[31:0];
            r_in.hue       <= s_axis_tdata[40:32];
            r_in.run_time  <= s_axis_tdata[56:41];
            r_in.run_speed <= s_axis_tdata[67:57];
        end
    end

    // Run state
    logic               r_run_active, n_run_active;
    logic [31:0]        r_run_start, n_run_start;
    logic [15:0]        r_run_length, n_run_length;
    logic signed [10:0] r_speed_now, n_speed_now;
    logic               r_eject_active, n_eject_active;
    logic [31:0]        r_eject_start, n_eject_start;
    logic               r_ring_seen, n_ring_seen;
    logic [31:0]        r_seen_time, n_seen_time;
    logic [31:0]        r_cooldown_until, n_cooldown_until;
    logic signed [10:0] r_motor, n_motor;
    logic               r_running, n_running;

    logic [31:0]        run_elapsed;
    logic [31:0]        eject_elapsed;
    logic [31:0]        seen_elapsed;
    logic signed [10:0] drive_cmd;
    logic               hue_hit;

    assign run_elapsed   = r_in.now_ms - r_run_start;
    assign eject_elapsed = r_in.now_ms - r_eject_start;
    assign seen_elapsed  = r_in.now_ms - r_seen_time;

    // Saturate the negation of the most negative speed
    assign drive_cmd = (r_speed_now == SPEED_NEG_FULL) ? SPEED_POS_MAX : -r_speed_now;

    assign hue_hit = r_team_is_blue ? (r_in.hue <= RED_HUE_MAX)
                                    : (r_in.hue >= BLUE_HUE_MIN && r_in.hue <= BLUE_HUE_MAX);

    always_comb begin
        n_run_active     = r_run_active;
        n_run_start      = r_run_start;
        n_run_length     = r_run_length;
        n_speed_now      = r_speed_now;
        n_eject_active   = r_eject_active;
        n_eject_start    = r_eject_start;
        n_ring_seen      = r_ring_seen;
        n_seen_time      = r_seen_time;
        n_cooldown_until = r_cooldown_until;
        n_motor          = r_motor;
        n_running        = r_run_active;
        case (r_in.mode)
            MODE_START: begin
                n_run_start      = r_in.now_ms;
                n_run_length     = r_in.run_time;
                n_run_active     = 1'b1;
                n_eject_active   = 1'b0;
                n_ring_seen      = 1'b0;
                n_cooldown_until = 32'd0;
                n_speed_now      = r_in.run_speed;
                n_running        = 1'b1;
            end
            MODE_CLEAR: begin
                n_run_start      = 32'd0;
                n_run_length     = 16'd0;
                n_run_active     = 1'b0;
                n_eject_active   = 1'b0;
                n_ring_seen      = 1'b0;
                n_cooldown_until = 32'd0;
                n_speed_now      = r_default_speed;
                n_running        = 1'b0;
            end
            MODE_TICK: begin
                n_running = r_run_active && (run_elapsed < {16'd0, r_run_length});
                if (!n_running) begin
                    // window closed: stop and drop the run
                    n_motor          = 11'sd0;
                    n_run_active     = 1'b0;
                    n_eject_active   = 1'b0;
                    n_ring_seen      = 1'b0;
                    n_cooldown_until = 32'd0;
                    n_speed_now      = r_default_speed;
                end else if (!r_sort_enable) begin
                    n_motor = drive_cmd;
                end else if (r_eject_active) begin
                    if (eject_elapsed < {16'd0, r_eject_ms}) begin
                        n_motor = 11'sd0;
                    end else begin
                        // eject done, keep the held command
                        n_eject_active = 1'b0;
                        n_ring_seen    = 1'b0;
                    end
                end else if (r_ring_seen) begin
                    if (seen_elapsed >= {16'd0, r_travel_ms}) begin
                        n_eject_active = 1'b1;
                        n_eject_start  = r_in.now_ms;
                        n_ring_seen    = 1'b0;
                    end
                    n_motor = drive_cmd;
                end else begin
                    n_motor = drive_cmd;
                    if (hue_hit && r_in.now_ms >= r_cooldown_until) begin
                        n_ring_seen      = 1'b1;
                        n_seen_time      = r_in.now_ms;
                        n_cooldown_until = r_in.now_ms + {16'd0, r_cooldown_ms};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active     <= 1'b0;
            r_run_start      <= 32'd0;
            r_run_length     <= 16'd0;
            r_speed_now      <= DEFAULT_SPEED_RST;
            r_eject_active   <= 1'b0;
            r_eject_start    <= 32'd0;
            r_ring_seen      <= 1'b0;
            r_seen_time      <= 32'd0;
            r_cooldown_until <= 32'd0;
            r_motor          <= 11'sd0;
            r_running        <= 1'b0;
        end else if (fire) begin
            r_run_active     <= n_run_active;
            r_run_start      <= n_run_start;
            r_run_length     <= n_run_length;
            r_speed_now      <= n_speed_now;
            r_eject_active   <= n_eject_active;
            r_eject_start    <= n_eject_start;
            r_ring_seen      <= n_ring_seen;
            r_seen_time      <= n_seen_time;
            r_cooldown_until <= n_cooldown_until;
            r_motor          <= n_motor;
            r_running        <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result fields come straight from the updated state registers
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_ring_seen, r_eject_active, r_running, r_motor};

endmodule

### sv/tics_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tics_chk
// Port-level checks for the timed intake color sorter, bound to the top level.
// ----------------------------------------------------------------------------
module tics_chk
    import tics_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Eject pause and pending ring only exist inside an open run window
    a_eject_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[12] || m_axis_tdata[13]) |-> m_axis_tdata[11])
        else $error("eject or pending ring outside run window");

    // A ring cannot be pending while an eject is in progress
    a_eject_ring_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[12] && m_axis_tdata[13]))
        else $error("ejecting and ring pending together");

    // The drive command is negated and saturated, so it never reaches full negative
    a_motor_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:0] != SPEED_NEG_FULL)
        else $error("motor command out of range");

endmodule

bind timed_intake_color_sorter_top tics_chk u_tics_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timed intake color sorter. Directed runs cover
// the window edges, speed saturation, both hue bands and the cooldown wrap;
// random runs, mostly of start and tick items, follow under changing register
// settings and stream stalls. A local model of the run state predicts every
// result, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import tics_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              pending;
        logic              ejecting;
        logic              running;
        logic signed [10:0] velocity;
    } t_motor_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    timed_intake_color_sorter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Register shadow
    logic              cfg_sort;
    logic              cfg_team_blue;
    logic [15:0]       cfg_eject;
    logic [15:0]       cfg_travel;
    logic [15:0]       cfg_cool;
    logic signed [10:0] cfg_dflt;

    // Run state shadow
    logic              run_on;
    logic [31:0]       run_t0;
    logic [15:0]       run_len;
    logic signed [10:0] spd_now;
    logic              eject_on;
    logic [31:0]       eject_t0;
    logic              ring_on;
    logic [31:0]       seen_t;
    logic [31:0]       cool_until;
    logic signed [10:0] motor_held;

    t_motor_cmd expected_cmds[$];

    int          errors;
    int          n_items;
    int          n_results;
    int          n_ejects;
    int          n_settings;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold;
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [10:0] drive_speed();
        // Negating the most negative code saturates
        if (spd_now == SPEED_NEG_FULL) begin
            return SPEED_POS_MAX;
        end
        return -spd_now;
    endfunction

    function void clear_run();
        run_on     = 1'b0;
        eject_on   = 1'b0;
        ring_on    = 1'b0;
        cool_until = '0;
        spd_now    = cfg_dflt;
    endfunction

    function void reset_model();
        cfg_sort      = 1'b0;
        cfg_team_blue = 1'b1;
        cfg_eject     = EJECT_MS_RST;
        cfg_travel    = TRAVEL_MS_RST;
        cfg_cool      = COOLDOWN_MS_RST;
        cfg_dflt      = DEFAULT_SPEED_RST;
        run_t0        = '0;
        run_len       = '0;
        eject_t0      = '0;
        seen_t        = '0;
        motor_held    = '0;
        clear_run();
    endfunction

    function automatic t_motor_cmd predict_motor_cmd(t_item it);
        logic       win;
        logic       hit;
        t_motor_cmd r;
        win = run_on;
        case (it.mode)
            MODE_START: begin
                run_t0     = it.now_ms;
                run_len    = it.run_time;
                run_on     = 1'b1;
                eject_on   = 1'b0;
                ring_on    = 1'b0;
                cool_until = '0;
                spd_now    = it.run_speed;
                win        = 1'b1;
            end
            MODE_CLEAR: begin
                run_t0  = '0;
                run_len = '0;
                clear_run();
                win     = 1'b0;
            end
            MODE_TICK: begin
                win = run_on && ((it.now_ms - run_t0) < {16'd0, run_len});
                if (!win) begin
                    motor_held = '0;
                    clear_run();
                end else if (!cfg_sort) begin
                    motor_held = drive_speed();
                end else if (eject_on) begin
                    // the tick that ends an ejection keeps the held command
                    if ((it.now_ms - eject_t0) < {16'd0, cfg_eject}) begin
                        motor_held = '0;
                    end else begin
                        eject_on = 1'b0;
                        ring_on  = 1'b0;
                    end
                end else if (ring_on) begin
                    if ((it.now_ms - seen_t) >= {16'd0, cfg_travel}) begin
                        eject_on = 1'b1;
                        eject_t0 = it.now_ms;
                        ring_on  = 1'b0;
                        n_ejects++;
                    end
                    motor_held = drive_speed();
                end else begin
                    motor_held = drive_speed();
                    hit = cfg_team_blue ? (it.hue <= RED_HUE_MAX)
                                        : (it.hue >= BLUE_HUE_MIN && it.hue <= BLUE_HUE_MAX);
                    // plain unsigned compare, even when the cooldown end wrapped
                    if (hit && it.now_ms >= cool_until) begin
                        ring_on    = 1'b1;
                        seen_t     = it.now_ms;
                        cool_until = it.now_ms + {16'd0, cfg_cool};
                    end
                end
            end
            default: ;
        endcase
        r.velocity = motor_held;
        r.running  = win;
        r.ejecting = eject_on;
        r.pending  = ring_on;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [31:0] now,
                             input logic [8:0] hue, input logic [15:0] rt,
                             input logic [10:0] spd);
        t_item it;
        it.mode      = mode;
        it.now_ms    = now;
        it.hue       = hue;
        it.run_time  = rt;
        it.run_speed = spd;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, it.run_speed, it.run_time, it.hue, it.now_ms};
        s_axis_tuser  <= it.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_cmds.push_back(predict_motor_cmd(it));
        n_items++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SORT_ENABLE:   cfg_sort      = value[0];
            REG_TEAM_IS_BLUE:  cfg_team_blue = value[0];
            REG_EJECT_MS:      cfg_eject     = value[15:0];
            REG_TRAVEL_MS:     cfg_travel    = value[15:0];
            REG_COOLDOWN_MS:   cfg_cool      = value[15:0];
            REG_DEFAULT_SPEED: cfg_dflt      = value[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic sort, input logic team, input logic [15:0] ej,
                              input logic [15:0] tr, input logic [15:0] cd,
                              input logic [10:0] ds);
        // quiesce the stream, then allow the pipeline latency to pass
        idle_input();
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(REG_SORT_ENABLE, {31'd0, sort});
        write_reg(REG_TEAM_IS_BLUE, {31'd0, team});
        write_reg(REG_EJECT_MS, {16'd0, ej});
        write_reg(REG_TRAVEL_MS, {16'd0, tr});
        write_reg(REG_COOLDOWN_MS, {16'd0, cd});
        write_reg(REG_DEFAULT_SPEED, {{21{ds[10]}}, ds});
        n_settings++;
    endtask

    function automatic logic [8:0] pick_hue();
        logic [8:0] edges[6] = '{9'd25, 9'd26, 9'd99, 9'd100, 9'd220, 9'd221};
        int         r;
        r = $urandom_range(0, 99);
        if (r < 25) return 9'($urandom_range(0, 25));
        if (r < 50) return 9'($urandom_range(100, 220));
        if (r < 60) return edges[$urandom_range(0, 5)];
        if (r < 95) return 9'($urandom_range(0, 359));
        return 9'($urandom_range(360, 511));
    endfunction

    // Mostly well-formed runs: a start followed by ticks at rising times,
    // with stray clears, restarts and fully random items mixed in.
    task automatic run_random(input int n);
        int          left;
        int          ticks;
        int          r;
        logic [15:0] rt;
        logic [10:0] spd;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 6) begin
                send_item(2'($urandom_range(0, 3)), $urandom, 9'($urandom_range(0, 511)),
                          16'($urandom), 11'($urandom));
                left--;
            end else begin
                if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
                rt  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(20, 600));
                spd = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                  : 11'($urandom_range(0, 1200) - 600);
                send_item(MODE_START, clock_ms, 9'($urandom), rt, spd);
                left--;
                ticks = $urandom_range(5, 40);
                while (ticks > 0 && left > 0) begin
                    clock_ms = clock_ms + $urandom_range(0, 25);
                    r = $urandom_range(0, 99);
                    if (r < 2) begin
                        send_item(MODE_CLEAR, clock_ms, pick_hue(), 16'($urandom), 11'($urandom));
                    end else if (r < 4) begin
                        send_item(MODE_UNUSED, clock_ms, pick_hue(), 16'($urandom),
                                  11'($urandom));
                    end else if (r < 6) begin
                        send_item(MODE_START, clock_ms, pick_hue(),
                                  16'($urandom_range(20, 600)),
                                  11'($urandom_range(0, 1200) - 600));
                    end else begin
                        send_item(MODE_TICK, clock_ms, pick_hue(), 16'($urandom), 11'($urandom));
                    end
                    ticks--;
                    left--;
                end
            end
        end
    endtask

    task automatic test_plain_run();
        tx_idle_pct = 22;
        rx_idle_pct = 63;
        send_item(MODE_UNUSED, 32'd0, 9'd0, 16'd0, 11'd0);
        send_item(MODE_START, 32'd1000, 9'd0, 16'd100, 11'sd600);
        send_item(MODE_TICK, 32'd1000, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd1099, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd1100, 9'd0, 16'd0, 11'd0);
        send_item(MODE_START, 32'd2000, 9'd0, 16'hFFFF, SPEED_NEG_FULL);
        send_item(MODE_TICK, 32'd2001, 9'd0, 16'd0, 11'd0);
        send_item(MODE_CLEAR, 32'd2002, 9'd0, 16'd0, 11'd0);
        // window that straddles the timestamp wrap
        send_item(MODE_START, 32'hFFFF_FFF0, 9'd0, 16'h0020, SPEED_POS_MAX);
        send_item(MODE_TICK, 32'h0000_000F, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'h0000_0010, 9'd0, 16'd0, 11'd0);
    endtask

    task automatic test_sort_directed();
        set_config(1'b1, 1'b1, 16'd30, 16'd20, 16'd100, -11'sd600);
        send_item(MODE_START, 32'd5000, 9'd0, 16'hFFFF, -11'sd600);
        send_item(MODE_TICK, 32'd5000, 9'd511, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd5001, 9'd25, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd5020, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd5021, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd5050, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd5051, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd5060, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'd5101, 9'd0, 16'd0, 11'd0);
        // blue band; the cooldown end wraps past zero and allows an early hit
        set_config(1'b1, 1'b0, 16'd30, 16'd20, 16'd100, -11'sd600);
        send_item(MODE_START, 32'hFFFF_FFB0, 9'd0, 16'hFFFF, 11'sd300);
        send_item(MODE_TICK, 32'hFFFF_FFB0, 9'd99, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'hFFFF_FFB1, 9'd221, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'hFFFF_FFB2, 9'd100, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'hFFFF_FFD0, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'hFFFF_FFEE, 9'd0, 16'd0, 11'd0);
        send_item(MODE_TICK, 32'hFFFF_FFF0, 9'd220, 16'd0, 11'd0);
    endtask

    task automatic test_random_sender_idle();
        set_config(1'b1, 1'b1, 16'd40, 16'd25, 16'd80, -11'sd600);
        tx_idle_pct = 22;
        rx_idle_pct = 63;
        run_random(450);
    endtask

    task automatic test_random_receiver_idle();
        set_config(1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 11'sd600);
        tx_idle_pct = 63;
        rx_idle_pct = 22;
        run_random(450);
    endtask

    task automatic test_random_no_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, SPEED_NEG_FULL);
        run_random(200);
        set_config(1'b0, 1'b0, 16'd15, 16'd5, 16'd30, SPEED_POS_MAX);
        run_random(200);
    endtask

    task automatic test_output_backpressure();
        set_config(1'b1, 1'b1, 16'd40, 16'd10, 16'd60, 11'sd450);
        tx_idle_pct = 0;
        rx_idle_pct = 20;
        // long receiver hold while the sender keeps offering
        rx_hold = 300;
        run_random(100);
    endtask

    task automatic test_drain_pause();
        run_random(20);
        idle_input();
        wait_drained();
        run_random(20);
    endtask

    // Receiver: random stalls, or a long hold when one is requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_motor_cmd want;
        t_motor_cmd got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[13:0];
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
            end else begin
                want = expected_cmds.pop_front();
                n_results++;
                if (got.velocity !== want.velocity)
                    report_field("motor_velocity", want.velocity, got.velocity);
                if (got.running !== want.running)
                    report_field("running", want.running, got.running);
                if (got.ejecting !== want.ejecting)
                    report_field("ejecting", want.ejecting, got.ejecting);
                if (got.pending !== want.pending)
                    report_field("ring_pending", want.pending, got.pending);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        errors        = 0;
        n_items       = 0;
        n_results     = 0;
        n_ejects      = 0;
        n_settings    = 1;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rx_hold       = 0;
        clock_ms      = 32'd100000;
        reset_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_run();
        test_sort_directed();
        test_random_sender_idle();
        test_random_receiver_idle();
        test_random_no_idle();
        test_output_backpressure();
        test_drain_pause();

        idle_input();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Run summary: %0d items sent, %0d results checked, %0d register settings.",
                 n_items, n_results, n_settings);
        $display("Covered %0d predicted ejections, timestamp wrap, speed saturation and stalls.",
                 n_ejects);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
